### hw/rtl/triangle_unit_normal_unit_assert.svh
// -----------------------------------------------------------------------------
// Triangle unit normal - assertion macros
// Concurrent assertion wrappers clocked on clk_i, used by the top level.
// -----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH

// checked only outside reset
`define TUN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TUN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/tun_pkg.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - package
// Shared constants, sideband type and a helper function.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int unsigned CoordWidthDef = 24;
  localparam int unsigned NormalFracDef = 14;
  // difference magnitudes are kept below 2^DiffLimitLog before the multiply
  localparam int unsigned DiffLimitLog  = 30;
  // the largest normalised cross magnitude lies in [2^30, 2^31)
  localparam int unsigned MantW         = 31;
  localparam int unsigned SumW          = 64;
  localparam int unsigned RootW         = 32;
  localparam int unsigned QueueDepth    = 2;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;    // output component gets negated
  } side_t;

  // leading zeros of a byte; an all-zero byte gives 7 (never selected)
  function automatic logic [2:0] lead_zeros8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int b = 0; b < 8; b++) begin
      if (v[b]) n = 3'(7 - b);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tun_fifo.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - decoupling queue
// Small flop-based FIFO between the front and back sections.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tun_front.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - front section
// Forms the edge vectors of a triangle, pre-scales wide differences and registers them.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_front #(
  parameter int unsigned COORD_WIDTH = tun_pkg::CoordWidthDef,
  localparam int unsigned DiffW =
    ((COORD_WIDTH > tun_pkg::DiffLimitLog) ? tun_pkg::DiffLimitLog : COORD_WIDTH) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [8:0][COORD_WIDTH-1:0] coord_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [5:0][DiffW-1:0]       diff_o
);

  import tun_pkg::*;

  localparam int unsigned MagBits = DiffW - 1;
  localparam int unsigned KMax    =
    (COORD_WIDTH > DiffLimitLog) ? COORD_WIDTH - DiffLimitLog : 0;
  localparam int unsigned KW      = $clog2(KMax + 2);

  logic signed [COORD_WIDTH:0]   diff [6];
  logic [COORD_WIDTH-1:0]        mag  [6];
  logic [COORD_WIDTH-1:0]        mag_or;
  logic [KW-1:0]                 k;
  logic [DiffW-1:0]              tmp;
  logic [5:0][DiffW-1:0]         diff_d, diff_q;
  logic                          valid_q;

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign diff_o      = diff_q;

  always_comb begin
    // edge vectors: b - c, then a - b
    for (int i = 0; i < 3; i++) begin
      diff[i]   = $signed({coord_i[3+i][COORD_WIDTH-1], coord_i[3+i]})
                - $signed({coord_i[6+i][COORD_WIDTH-1], coord_i[6+i]});
      diff[3+i] = $signed({coord_i[i][COORD_WIDTH-1], coord_i[i]})
                - $signed({coord_i[3+i][COORD_WIDTH-1], coord_i[3+i]});
    end
    mag_or = '0;
    for (int i = 0; i < 6; i++) begin
      mag[i] = diff[i][COORD_WIDTH] ? COORD_WIDTH'(-diff[i]) : COORD_WIDTH'(diff[i]);
      mag_or = mag_or | mag[i];
    end
    // common right shift so that every magnitude stays below 2^30
    k = '0;
    for (int b = DiffLimitLog; b < COORD_WIDTH; b++) begin
      if (mag_or[b]) k = KW'(b - DiffLimitLog + 1);
    end
    for (int i = 0; i < 6; i++) begin
      tmp       = {1'b0, MagBits'(mag[i] >> k)};
      diff_d[i] = diff[i][COORD_WIDTH] ? -tmp : tmp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      diff_q <= diff_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tun_sqrt.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - square root pipeline
// Restoring integer square root, one root bit per stage, with a sideband.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tun_pkg::SumW-1:0]   s_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [tun_pkg::RootW-1:0]  root_o,
  output logic [SW-1:0]              side_o
);

  import tun_pkg::*;

  logic [SumW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [SW-1:0]    side_q [RootW];
  logic [RootW-1:0] vld_q;

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int unsigned Bit = RootW - 1 - j;
    logic [SumW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SW-1:0]    side_in;
    logic             vld_in;
    logic [SumW+1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_in  = s_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    // (root + 2^Bit)^2 - root^2
    assign trial = ((SumW+2)'(root_in) << (Bit + 1)) | ((SumW+2)'(1) << (2 * Bit));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b00, rem_in} >= trial) begin
          rem_q[j]  <= rem_in - trial[SumW-1:0];
          root_q[j] <= root_in | (RootW'(1) << Bit);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

`default_nettype wire

### hw/rtl/tun_div.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - divider pipeline
// Three rounded quotients m * 2^F / r, one quotient bit per stage, shared r.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_div #(
  parameter int unsigned NORMAL_FRAC = tun_pkg::NormalFracDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [tun_pkg::RootW-1:0]         root_i,
  input  logic [2:0][tun_pkg::MantW-1:0]    m_i,
  input  tun_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [2:0][NORMAL_FRAC:0]         q_o,
  output tun_pkg::side_t                    side_o
);

  import tun_pkg::*;

  localparam int unsigned NW = MantW + NORMAL_FRAC + 1;
  localparam int unsigned QW = NORMAL_FRAC + 1;

  // dividend set-up stage
  logic [2:0][NW-1:0] num_q;
  logic [RootW-1:0]   r0_q;
  side_t              side0_q;
  logic               vld0_q;

  logic [2:0][NW-1:0] rem_q  [QW];
  logic [2:0][QW-1:0] quo_q  [QW];
  logic [RootW-1:0]   r_q    [QW];
  side_t              side_q [QW];
  logic [QW-1:0]      vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        // half the divisor added for round to nearest
        num_q[l] <= (NW'(m_i[l]) << NORMAL_FRAC) + NW'(root_i >> 1);
      end
      r0_q    <= root_i;
      side0_q <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - j;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [RootW-1:0]   r_in;
    side_t              side_in;
    logic               vld_in;
    logic [NW-1:0]      dvs;

    if (j == 0) begin : g_first
      assign rem_in  = num_q;
      assign quo_in  = '0;
      assign r_in    = r0_q;
      assign side_in = side0_q;
      assign vld_in  = vld0_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign r_in    = r_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign dvs = NW'(r_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dvs) begin
            rem_q[j][l] <= rem_in[l] - dvs;
            quo_q[j][l] <= quo_in[l] | (QW'(1) << Bit);
          end else begin
            rem_q[j][l] <= rem_in[l];
            quo_q[j][l] <= quo_in[l];
          end
        end
        r_q[j]    <= r_in;
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign q_o     = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

### hw/rtl/tun_back.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - back section
// Cross product, block normalisation, length, division and output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_back #(
  parameter int unsigned COORD_WIDTH = tun_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC = tun_pkg::NormalFracDef,
  localparam int unsigned DiffW =
    ((COORD_WIDTH > tun_pkg::DiffLimitLog) ? tun_pkg::DiffLimitLog : COORD_WIDTH) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [5:0][DiffW-1:0]         diff_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0][NORMAL_FRAC+1:0]   norm_o,
  output logic                          degen_o
);

  import tun_pkg::*;

  localparam int unsigned PW   = 2 * DiffW;          // product / cross width
  localparam int unsigned MW   = PW - 1;             // cross magnitude width
  localparam int unsigned AW   = (MW > MantW) ? MW : MantW;
  localparam int unsigned NG   = (AW + 7) / 8;
  localparam int unsigned PW8  = NG * 8;
  localparam int unsigned CGW  = $clog2(NG);
  localparam int unsigned SqW  = 2 * MantW;
  localparam int unsigned SW   = 3 * MantW + $bits(side_t);
  localparam int unsigned QW   = NORMAL_FRAC + 1;
  localparam int unsigned OW   = NORMAL_FRAC + 2;

  logic en;
  logic [10:1] vld_q;

  logic signed [DiffW-1:0] d [6];
  logic signed [PW-1:0]    prod_q [6];
  logic signed [PW-1:0]    crs_q  [3];
  logic [MW-1:0]           cmag_q [3];
  side_t                   side3_q, side4_q, side5_q, side6_q, side7_q, side8_q;
  side_t                   side9_q, side10_q;

  logic [PW8-1:0]          padded;
  logic [NG-1:0]           nz_q;
  logic [2:0]              lzc_q [NG];
  logic [AW-1:0]           am4_q [3];
  logic [CGW-1:0]          cs_d, cs_q;
  logic [2:0]              fs_d, fs5_q, fs6_q;
  logic [AW-1:0]           am5_q [3];
  logic [AW-1:0]           am6_q [3];
  logic [AW-1:0]           fine  [3];
  logic [2:0][MantW-1:0]   m7_q, m8_q, m9_q, m10_q;
  logic [SqW-1:0]          sq_q [3];
  logic [SqW:0]            s01_q;
  logic [SqW-1:0]          sq2_q;
  logic [SumW-1:0]         s_q;

  logic                    sq_valid;
  logic [RootW-1:0]        root;
  logic [SW-1:0]           sq_side;
  logic [2:0][MantW-1:0]   dv_m;
  side_t                   dv_side_in;

  logic                    dv_valid;
  logic [2:0][QW-1:0]      quo;
  side_t                   dv_side;
  logic [QW-1:0]           qc;
  logic [2:0][OW-1:0]      norm_d, norm_q;
  logic                    out_valid_q;
  logic                    degen_q;

  // the whole back section advances together
  assign en          = ~out_valid_q | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign norm_o      = norm_q;
  assign degen_o     = degen_q;

  always_comb begin
    for (int i = 0; i < 6; i++) d[i] = $signed(diff_i[i]);
  end

  // chunked leading-zero search on the OR of the magnitudes
  always_comb begin
    padded = PW8'(AW'(cmag_q[0] | cmag_q[1] | cmag_q[2])) << (PW8 - AW);
  end

  always_comb begin
    cs_d = '0;
    fs_d = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (nz_q[g]) begin
        cs_d = CGW'(g);
        fs_d = lzc_q[g];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) fine[l] = am6_q[l] << fs6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products: r1 = d[0..2], r2 = d[3..5]
      prod_q[0] <= d[1] * d[5];
      prod_q[1] <= d[4] * d[2];
      prod_q[2] <= d[2] * d[3];
      prod_q[3] <= d[0] * d[5];
      prod_q[4] <= d[0] * d[4];
      prod_q[5] <= d[3] * d[1];

      crs_q[0] <= prod_q[0] - prod_q[1];
      crs_q[1] <= prod_q[2] - prod_q[3];
      crs_q[2] <= prod_q[4] - prod_q[5];

      for (int l = 0; l < 3; l++) begin
        cmag_q[l]      <= crs_q[l][PW-1] ? MW'(-crs_q[l]) : MW'(crs_q[l]);
        side3_q.neg[l] <= ~crs_q[l][PW-1] && (crs_q[l] != '0);
      end
      side3_q.degen <= (crs_q[0] == '0) && (crs_q[1] == '0) && (crs_q[2] == '0);

      for (int g = 0; g < NG; g++) begin
        nz_q[g]  <= |padded[PW8-1-8*g -: 8];
        lzc_q[g] <= lead_zeros8(padded[PW8-1-8*g -: 8]);
      end
      for (int l = 0; l < 3; l++) am4_q[l] <= AW'(cmag_q[l]);
      side4_q <= side3_q;

      cs_q    <= cs_d;
      fs5_q   <= fs_d;
      am5_q   <= am4_q;
      side5_q <= side4_q;

      for (int l = 0; l < 3; l++) am6_q[l] <= am5_q[l] << {cs_q, 3'b000};
      fs6_q   <= fs5_q;
      side6_q <= side5_q;

      // leading one now at the top: keep 31 bits
      for (int l = 0; l < 3; l++) m7_q[l] <= fine[l][AW-1 -: MantW];
      side7_q <= side6_q;

      for (int l = 0; l < 3; l++) sq_q[l] <= m7_q[l] * m7_q[l];
      m8_q    <= m7_q;
      side8_q <= side7_q;

      s01_q   <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
      sq2_q   <= sq_q[2];
      m9_q    <= m8_q;
      side9_q <= side8_q;

      s_q      <= SumW'(s01_q) + SumW'(sq2_q);
      m10_q    <= m9_q;
      side10_q <= side9_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[9:1], in_valid_i};
    end
  end

  tun_sqrt #(
    .SW (SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[10]),
    .s_i     (s_q),
    .side_i  ({m10_q, side10_q}),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign dv_m       = sq_side[SW-1 -: 3*MantW];
  assign dv_side_in = sq_side[$bits(side_t)-1:0];

  tun_div #(
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (root),
    .m_i     (dv_m),
    .side_i  (dv_side_in),
    .valid_o (dv_valid),
    .q_o     (quo),
    .side_o  (dv_side)
  );

  always_comb begin
    qc = '0;
    for (int l = 0; l < 3; l++) begin
      qc = (quo[l] > (QW'(1) << NORMAL_FRAC)) ? (QW'(1) << NORMAL_FRAC) : quo[l];
      if (dv_side.degen) begin
        norm_d[l] = '0;
      end else if (dv_side.neg[l]) begin
        norm_d[l] = -OW'(qc);
      end else begin
        norm_d[l] = OW'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_q  <= norm_d;
      degen_q <= dv_side.degen;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/triangle_unit_normal_unit.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - top level
// Unit face normal of a triangle in signed Q1.NORMAL_FRAC, one per clock while results are popped.
// -----------------------------------------------------------------------------
// Takes one triangle per clock while full is low and returns its negated unit
// normal, rounded to nearest, with degenerate_o set (and a zero normal) when the
// cross product is zero. Sustained rate is one triangle per cycle while results
// are popped. From push to result a triangle passes the input register, the
// queue, the cross product and normalisation stages, the 32-stage square root
// with one root bit per stage, the divider and the output register. A stall on
// pop holds the back pipeline; the front register and a two-entry queue keep
// accepting up to three triangles.
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal_unit #(
  parameter int unsigned COORD_WIDTH = tun_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC = tun_pkg::NormalFracDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_z_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_z_i,
  input  logic signed [COORD_WIDTH-1:0] c_x_i,
  input  logic signed [COORD_WIDTH-1:0] c_y_i,
  input  logic signed [COORD_WIDTH-1:0] c_z_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [NORMAL_FRAC+1:0] norm_x_o,
  output logic signed [NORMAL_FRAC+1:0] norm_y_o,
  output logic signed [NORMAL_FRAC+1:0] norm_z_o,
  output logic                          degenerate_o
);

  import tun_pkg::*;

  localparam int unsigned DiffW =
    ((COORD_WIDTH > DiffLimitLog) ? DiffLimitLog : COORD_WIDTH) + 1;
  localparam int unsigned OW    = NORMAL_FRAC + 2;
  localparam logic signed [OW-1:0] UnitPos = OW'(1) << NORMAL_FRAC;

  logic [8:0][COORD_WIDTH-1:0] coord;
  logic                        in_ready;
  logic                        front_valid;
  logic [5:0][DiffW-1:0]       front_diff;
  logic                        fifo_full;
  logic                        fifo_empty;
  logic [5:0][DiffW-1:0]       fifo_data;
  logic                        back_ready;
  logic                        back_valid;
  logic [2:0][OW-1:0]          norm;

  assign coord[0] = a_x_i;
  assign coord[1] = a_y_i;
  assign coord[2] = a_z_i;
  assign coord[3] = b_x_i;
  assign coord[4] = b_y_i;
  assign coord[5] = b_z_i;
  assign coord[6] = c_x_i;
  assign coord[7] = c_y_i;
  assign coord[8] = c_z_i;

  assign full = ~in_ready;

  tun_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .coord_i     (coord),
    .out_valid_o (front_valid),
    .out_ready_i (~fifo_full),
    .diff_o      (front_diff)
  );

  tun_fifo #(
    .WIDTH ($bits(front_diff)),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_diff),
    .full_o  (fifo_full),
    .pop_i   (back_ready),
    .data_o  (fifo_data),
    .empty_o (fifo_empty)
  );

  tun_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .NORMAL_FRAC (NORMAL_FRAC)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (~fifo_empty),
    .in_ready_o  (back_ready),
    .diff_i      (fifo_data),
    .out_valid_o (back_valid),
    .out_ready_i (pop),
    .norm_o      (norm),
    .degen_o     (degenerate_o)
  );

  assign empty    = ~back_valid;
  assign norm_x_o = $signed(norm[0]);
  assign norm_y_o = $signed(norm[1]);
  assign norm_z_o = $signed(norm[2]);

  `include "triangle_unit_normal_unit_assert.svh"

  `TUN_ASSERT_RST(a_rst_empty, !rst_ni |=> empty, "result queue not empty after reset")
  `TUN_ASSERT(a_degen_zero, !empty && degenerate_o |-> norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0, "degenerate result with non-zero normal")
  `TUN_ASSERT(a_unit_bound, !empty |-> norm_x_o <= UnitPos && norm_x_o >= -UnitPos && norm_y_o <= UnitPos && norm_y_o >= -UnitPos && norm_z_o <= UnitPos && norm_z_o >= -UnitPos, "normal component beyond unit range")
  `TUN_ASSERT(a_front_move, push && !full && front_valid |-> !fifo_full, "front overwritten while its item was not transferred")

endmodule

`default_nettype wire

### tb/sv/tun_checker.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - result checker
// Watches the triangle and normal transfers, predicts each normal and compares.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_checker #(
  parameter int unsigned CW = 24,
  parameter int unsigned NF = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  logic signed [CW-1:0] a_x_i, a_y_i, a_z_i,
  input  logic signed [CW-1:0] b_x_i, b_y_i, b_z_i,
  input  logic signed [CW-1:0] c_x_i, c_y_i, c_z_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic signed [NF+1:0] norm_x_o, norm_y_o, norm_z_o,
  input  logic                 degenerate_o,
  output int                   fail_count,
  output int                   pending,
  output int                   degen_seen,
  output int                   normals_seen
);

  typedef struct packed {
    logic [NF+1:0] nx;
    logic [NF+1:0] ny;
    logic [NF+1:0] nz;
    logic          degen;
  } normal_t;

  normal_t normal_q[$];

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(input longint av[3], input longint bv[3],
                                          input longint cv[3]);
    longint e1[3], e2[3], cr[3];
    longint unsigned mg[3], cmax, s, r, q;
    normal_t res;
    e1[0] = bv[0] - cv[0]; e1[1] = bv[1] - cv[1]; e1[2] = bv[2] - cv[2];
    e2[0] = av[0] - bv[0]; e2[1] = av[1] - bv[1]; e2[2] = av[2] - bv[2];
    // 24-bit coords: differences stay below 2^30, no pre-shift
    cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
    cmax = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mg[i] > cmax) cmax = mg[i];
    end
    res = '0;
    if (cmax == 0) begin
      res.degen = 1'b1;
      return res;
    end
    while (cmax >= (64'd1 << 31)) begin
      cmax >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (cmax < (64'd1 << 30)) begin
      cmax <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    r = root64(s);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      logic [NF+1:0] o;
      q = ((mg[i] << NF) + (r >> 1)) / r;
      if (q > (64'd1 << NF)) q = 64'd1 << NF;
      o = q[NF+1:0];
      if (cr[i] > 0) o = -o;
      if (i == 0) res.nx = o;
      else if (i == 1) res.ny = o;
      else res.nz = o;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    degen_seen = 0;
    normals_seen = 0;
  end

  assign pending = normal_q.size();

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      longint av[3], bv[3], cv[3];
      av = '{a_x_i, a_y_i, a_z_i};
      bv = '{b_x_i, b_y_i, b_z_i};
      cv = '{c_x_i, c_y_i, c_z_i};
      normal_q.push_back(face_normal(av, bv, cv));
    end
    if (rst_ni && pop && !empty) begin
      normal_t w;
      normals_seen++;
      if (degenerate_o === 1'b1) degen_seen++;
      if (normal_q.size() == 0) begin
        $display("normal transfer with none outstanding at %0t", $realtime);
        fail_count++;
      end else begin
        w = normal_q.pop_front();
        if (norm_x_o !== w.nx) report_mismatch("norm_x", norm_x_o, $signed(w.nx));
        if (norm_y_o !== w.ny) report_mismatch("norm_y", norm_y_o, $signed(w.ny));
        if (norm_z_o !== w.nz) report_mismatch("norm_z", norm_z_o, $signed(w.nz));
        if (degenerate_o !== w.degen) report_mismatch("degenerate", degenerate_o, w.degen);
      end
    end
  end

endmodule

### tb/sv/tb_triangle_unit_normal_unit.sv
// -----------------------------------------------------------------------------
// Triangle unit normal - testbench top
// Directed and random triangles with random gaps and stalls; the checker
// predicts every normal and counts mismatches.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_unit_normal_unit;

  localparam int unsigned CW = tun_pkg::CoordWidthDef;
  localparam int unsigned NF = tun_pkg::NormalFracDef;
  localparam int NRand = 600;
  localparam longint CycleLimit = 400000;
  localparam logic signed [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

  logic clk_i, rst_ni, push, full, empty, pop, degenerate_o;
  logic signed [CW-1:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i;
  logic signed [NF+1:0] norm_x_o, norm_y_o, norm_z_o;
  int fail_count, pending, degen_seen, normals_seen;
  int sent;
  bit stim_done, hold_rx;
  longint cycles;

  triangle_unit_normal_unit dut (.*);

  tun_checker #(.CW(CW), .NF(NF)) u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CMax;
      1: return CMin;
      2: return CW'($signed($urandom_range(0, 64)) - 32);
      default: return CW'($urandom());
    endcase
  endfunction

  // push stays high between back-to-back transfers; it only drops for a gap
  task automatic send_tri(input logic [CW-1:0] v[9]);
    int gap;
    gap = (stim_done || hold_rx) ? 0 : $urandom_range(0, 19);
    if (sent % 100 < 30) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    a_x_i <= v[0]; a_y_i <= v[1]; a_z_i <= v[2];
    b_x_i <= v[3]; b_y_i <= v[4]; b_z_i <= v[5];
    c_x_i <= v[6]; c_y_i <= v[7]; c_z_i <= v[8];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  // receiver: random stalls, one long hold-off early in the random phase
  initial begin
    int st;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      st = (normals_seen % 120 < 40) ? 0 : $urandom_range(0, 19);
      if (st != 0) begin
        pop <= 1'b0;
        repeat (st - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      pop <= 1'b1;
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [CW-1:0] v[9];
    sent = 0;
    stim_done = 0;
    hold_rx = 0;
    push = 0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate (all equal, collinear), axis-aligned, extremes
    v = '{default: '0};                                    send_tri(v);
    v = '{default: CMax};                                  send_tri(v);
    v = '{0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192};    send_tri(v);
    v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};                send_tri(v);
    v = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};                send_tri(v);
    v = '{0, 0, 0, 0, 0, 4096, 0, 4096, 0};                send_tri(v);
    v = '{0, 0, 0, 4096, 0, 0, 0, 0, 4096};                send_tri(v);
    v = '{CMax, CMax, CMax, CMin, CMin, CMin, CMax, CMin, CMax}; send_tri(v);
    v = '{CMin, 0, 0, 0, CMax, 0, 0, 0, CMin};             send_tri(v);
    v = '{CMax, CMin, 0, CMin, CMax, CMax, 0, CMin, CMax}; send_tri(v);
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                      send_tri(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                      send_tri(v);
    v = '{1, 2, 3, 4, 5, 6, 7, 8, 10};                     send_tri(v);
    v = '{CMax, 0, 0, CMin, 0, 0, 0, 0, 0};                send_tri(v);

    for (int n = 0; n < NRand; n++) begin
      if (n == 20) hold_rx = 1'b1;
      for (int i = 0; i < 9; i++) v[i] = rand_coord();
      // some degenerate: repeated vertex
      if ($urandom_range(0, 15) == 0) begin
        v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
      end
      send_tri(v);
    end
    push <= 1'b0;
    stim_done = 1;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("triangles sent: %0d, normals checked: %0d, degenerate: %0d",
             sent, normals_seen, degen_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tun_pkg.sv
hw/rtl/tun_fifo.sv
hw/rtl/tun_front.sv
hw/rtl/tun_sqrt.sv
hw/rtl/tun_div.sv
hw/rtl/tun_back.sv
hw/rtl/triangle_unit_normal_unit.sv
tb/sv/tun_checker.sv
tb/sv/tb_triangle_unit_normal_unit.sv
